@@ src/binomial_mod_prime_lucas_macros.svh @@
// assertion helpers used by the checker file
`ifndef BINOMIAL_MOD_PRIME_LUCAS_MACROS_SVH
`define BINOMIAL_MOD_PRIME_LUCAS_MACROS_SVH

// clocked assertion, masked while reset is held
`define BML_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define BML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bml_pkg.sv @@
package bml_pkg;

    localparam int unsigned VAL_W      = 12;
    localparam int unsigned NUM_W      = 63;
    localparam int unsigned IN_TDATA_W = 128;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned DIV_W      = 64;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned PROD_W     = 2 * VAL_W;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ZERO,
        OP_NDIV_GO,
        OP_NDIV_END,
        OP_RDIV_GO,
        OP_RDIV_END,
        OP_RD_A,
        OP_M1_GO,
        OP_M1_END,
        OP_M2_GO,
        OP_M2_END,
        OP_M3_GO,
        OP_M3_END,
        OP_B_INIT0,
        OP_B_INIT1,
        OP_B_DIV_GO,
        OP_B_DIV_END,
        OP_B_RDM,
        OP_B_MUL_GO,
        OP_B_MUL_END,
        OP_C_INIT0,
        OP_C_INIT1,
        OP_C_FGO,
        OP_C_FEND,
        OP_C_IGO,
        OP_C_IEND,
        OP_SET_READY,
        OP_OUT
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic div_done;
        logic p_bad;
        logic ready;
        logic r_gt_n;
        logic n_zero;
        logic dr_gt_dn;
        logic i_ge_p;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/bml_ram.sv @@
module bml_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bml_div.sv @@
module bml_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bml_pkg::DIV_W-1:0] dividend,
    input  logic [bml_pkg::CNT_W-1:0] nbits,
    input  logic [bml_pkg::VAL_W-1:0] divisor,
    output logic [bml_pkg::DIV_W-1:0] quotient,
    output logic [bml_pkg::VAL_W-1:0] remainder,
    output logic                      done
);
    import bml_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAL_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, dividend aligned to the top bits
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, divisor};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? VAL_W'(trial - {1'b0, divisor}) : trial[VAL_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ src/bml_datapath.sv @@
module bml_datapath #(
    parameter int MAX_PRIME = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bml_pkg::dp_op_t                 op,
    output bml_pkg::dp_status_t             status,
    input  logic [bml_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic [bml_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [bml_pkg::VAL_W-1:0]       cfg_wr_data
);
    import bml_pkg::*;

    localparam int AW = $clog2(MAX_PRIME);

    // control registers
    logic [VAL_W-1:0] mod_reg;
    logic             ready_reg;
    logic             out_valid_reg;
    // working registers
    logic [NUM_W-1:0] n_reg, r_reg;
    logic [VAL_W-1:0] dn_reg, dr_reg, ans_reg, acc_reg, i_reg, q_reg, m_reg;
    logic [VAL_W-1:0] fprev_reg, iprev_reg, out_data_reg;

    // divider and multiplier
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_nbits;
    logic [VAL_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic [VAL_W-1:0] div_rem;
    logic             div_done;
    logic [VAL_W-1:0] mul_a, mul_b;
    logic             mul_go;
    logic [PROD_W-1:0] prod;

    // table memories
    logic          fact_we, fact_re, inv_we, inv_re;
    logic [AW-1:0] fact_waddr, fact_raddr, inv_waddr, inv_raddr;
    logic [VAL_W-1:0] fact_wdata, inv_wdata, fact_rd, inv_rd;
    logic [VAL_W-1:0] neg_rem;

    assign prod    = {{VAL_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, mul_b};
    assign neg_rem = (div_rem == '0) ? '0 : mod_reg - div_rem;

    // p / i during the inverse build, p otherwise
    assign div_divisor = (op == OP_B_DIV_GO || op == OP_B_DIV_END) ? i_reg : mod_reg;

    // operand selection for the multiplier and the shared divider
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        mul_go       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_nbits    = '0;
        case (op)
            OP_NDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = {n_reg, 1'b0};
                div_nbits    = CNT_W'(NUM_W);
            end
            OP_RDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = {r_reg, 1'b0};
                div_nbits    = CNT_W'(NUM_W);
            end
            OP_B_DIV_GO: begin
                div_start    = 1'b1;
                div_dividend = {mod_reg, {(DIV_W-VAL_W){1'b0}}};
                div_nbits    = CNT_W'(VAL_W);
            end
            OP_M1_GO: begin
                mul_go = 1'b1;
                mul_a  = fact_rd;
                mul_b  = inv_rd;
            end
            OP_M2_GO: begin
                mul_go = 1'b1;
                mul_a  = acc_reg;
                mul_b  = inv_rd;
            end
            OP_M3_GO: begin
                mul_go = 1'b1;
                mul_a  = ans_reg;
                mul_b  = acc_reg;
            end
            OP_B_MUL_GO: begin
                mul_go = 1'b1;
                mul_a  = q_reg;
                mul_b  = inv_rd;
            end
            OP_C_FGO: begin
                mul_go = 1'b1;
                mul_a  = fprev_reg;
                mul_b  = i_reg;
            end
            OP_C_IGO: begin
                mul_go = 1'b1;
                mul_a  = inv_rd;
                mul_b  = iprev_reg;
            end
            default: begin
            end
        endcase
        if (mul_go) begin
            div_start    = 1'b1;
            div_dividend = {prod, {(DIV_W-PROD_W){1'b0}}};
            div_nbits    = CNT_W'(PROD_W);
        end
    end

    // table read and write ports
    always_comb begin
        fact_we    = 1'b0;
        fact_waddr = '0;
        fact_wdata = '0;
        fact_re    = 1'b0;
        fact_raddr = '0;
        inv_we     = 1'b0;
        inv_waddr  = '0;
        inv_wdata  = '0;
        inv_re     = 1'b0;
        inv_raddr  = '0;
        case (op)
            OP_RD_A: begin
                fact_re    = 1'b1;
                fact_raddr = AW'(dn_reg);
                inv_re     = 1'b1;
                inv_raddr  = AW'(VAL_W'(dn_reg - dr_reg));
            end
            OP_M1_GO: begin
                inv_re    = 1'b1;
                inv_raddr = AW'(dr_reg);
            end
            OP_B_INIT0: begin
                inv_we    = 1'b1;
                inv_waddr = '0;
                inv_wdata = '0;
            end
            OP_B_INIT1: begin
                inv_we    = 1'b1;
                inv_waddr = AW'(1);
                inv_wdata = VAL_W'(1);
            end
            OP_B_RDM: begin
                inv_re    = 1'b1;
                inv_raddr = AW'(m_reg);
            end
            OP_B_MUL_END: begin
                inv_we    = div_done;
                inv_waddr = AW'(i_reg);
                inv_wdata = neg_rem;
            end
            OP_C_INIT0: begin
                fact_we    = 1'b1;
                fact_waddr = '0;
                fact_wdata = VAL_W'(1);
                inv_we     = 1'b1;
                inv_waddr  = '0;
                inv_wdata  = VAL_W'(1);
            end
            OP_C_INIT1: begin
                fact_we    = 1'b1;
                fact_waddr = AW'(1);
                fact_wdata = VAL_W'(1);
            end
            OP_C_FGO: begin
                inv_re    = 1'b1;
                inv_raddr = AW'(i_reg);
            end
            OP_C_FEND: begin
                fact_we    = div_done;
                fact_waddr = AW'(i_reg);
                fact_wdata = div_rem;
            end
            OP_C_IEND: begin
                inv_we    = div_done;
                inv_waddr = AW'(i_reg);
                inv_wdata = div_rem;
            end
            default: begin
            end
        endcase
    end

    // modulus, table state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg       <= VAL_W'(2);
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
                if (cfg_wr_data != mod_reg) begin
                    ready_reg <= 1'b0;
                end
            end else if (op == OP_SET_READY) begin
                ready_reg <= 1'b1;
            end
            if (op == OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                n_reg   <= s_tdata[NUM_W-1:0];
                r_reg   <= s_tdata[2*NUM_W-1:NUM_W];
                ans_reg <= VAL_W'(1);
            end
            OP_ZERO: ans_reg <= '0;
            OP_NDIV_END: begin
                if (div_done) begin
                    n_reg  <= div_quo[NUM_W-1:0];
                    dn_reg <= div_rem;
                end
            end
            OP_RDIV_END: begin
                if (div_done) begin
                    r_reg  <= div_quo[NUM_W-1:0];
                    dr_reg <= div_rem;
                end
            end
            OP_M1_END, OP_M2_END: begin
                if (div_done) begin
                    acc_reg <= div_rem;
                end
            end
            OP_M3_END: begin
                if (div_done) begin
                    ans_reg <= div_rem;
                end
            end
            OP_B_INIT1, OP_C_INIT1: begin
                i_reg     <= VAL_W'(2);
                fprev_reg <= VAL_W'(1);
                iprev_reg <= VAL_W'(1);
            end
            OP_B_DIV_END: begin
                if (div_done) begin
                    q_reg <= div_quo[VAL_W-1:0];
                    m_reg <= div_rem;
                end
            end
            OP_B_MUL_END: begin
                if (div_done) begin
                    i_reg <= i_reg + VAL_W'(1);
                end
            end
            OP_C_FEND: begin
                if (div_done) begin
                    fprev_reg <= div_rem;
                end
            end
            OP_C_IEND: begin
                if (div_done) begin
                    iprev_reg <= div_rem;
                    i_reg     <= i_reg + VAL_W'(1);
                end
            end
            OP_OUT: out_data_reg <= ans_reg;
            default: begin
            end
        endcase
    end

    bml_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .nbits     (div_nbits),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    bml_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PRIME)) u_fact_ram (
        .aclk    (aclk),
        .wr_en   (fact_we),
        .wr_addr (fact_waddr),
        .wr_data (fact_wdata),
        .rd_en   (fact_re),
        .rd_addr (fact_raddr),
        .rd_data (fact_rd)
    );

    bml_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PRIME)) u_inv_ram (
        .aclk    (aclk),
        .wr_en   (inv_we),
        .wr_addr (inv_waddr),
        .wr_data (inv_wdata),
        .rd_en   (inv_re),
        .rd_addr (inv_raddr),
        .rd_data (inv_rd)
    );

    // status toward the controller
    always_comb begin
        status.div_done = div_done;
        status.p_bad    = (mod_reg < VAL_W'(2)) || (32'(mod_reg) > MAX_PRIME);
        status.ready    = ready_reg;
        status.r_gt_n   = r_reg > n_reg;
        status.n_zero   = n_reg == '0;
        status.dr_gt_dn = dr_reg > dn_reg;
        status.i_ge_p   = i_reg >= mod_reg;
        status.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-VAL_W){1'b0}}, out_data_reg};

endmodule

@@ src/bml_ctrl.sv @@
module bml_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bml_pkg::dp_status_t status,
    output bml_pkg::dp_op_t     op
);
    import bml_pkg::*;

    typedef enum logic [31:0] {
        ST_IDLE  = 32'b1 << 0,
        ST_CHECK = 32'b1 << 1,
        ST_BI0   = 32'b1 << 2,
        ST_BI1   = 32'b1 << 3,
        ST_BLOOP = 32'b1 << 4,
        ST_BDIVG = 32'b1 << 5,
        ST_BDIVW = 32'b1 << 6,
        ST_BRDM  = 32'b1 << 7,
        ST_BMULG = 32'b1 << 8,
        ST_BMULW = 32'b1 << 9,
        ST_CI0   = 32'b1 << 10,
        ST_CI1   = 32'b1 << 11,
        ST_CLOOP = 32'b1 << 12,
        ST_CFG   = 32'b1 << 13,
        ST_CFW   = 32'b1 << 14,
        ST_CIG   = 32'b1 << 15,
        ST_CIW   = 32'b1 << 16,
        ST_CMP   = 32'b1 << 17,
        ST_LTEST = 32'b1 << 18,
        ST_NDG   = 32'b1 << 19,
        ST_NDW   = 32'b1 << 20,
        ST_RDG   = 32'b1 << 21,
        ST_RDW   = 32'b1 << 22,
        ST_DTEST = 32'b1 << 23,
        ST_RDA   = 32'b1 << 24,
        ST_M1G   = 32'b1 << 25,
        ST_M1W   = 32'b1 << 26,
        ST_M2G   = 32'b1 << 27,
        ST_M2W   = 32'b1 << 28,
        ST_M3G   = 32'b1 << 29,
        ST_M3W   = 32'b1 << 30,
        ST_OUT   = 32'b1 << 31
    } state_t;

    state_t state_reg, state_next;

    // sequencing of query intake, checks, table build, digit loop and output
    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.p_bad) begin
                    op         = OP_ZERO;
                    state_next = ST_OUT;
                end else if (!status.ready) begin
                    state_next = ST_BI0;
                end else begin
                    state_next = ST_CMP;
                end
            end
            // inverse table by the linear recurrence
            ST_BI0: begin
                op         = OP_B_INIT0;
                state_next = ST_BI1;
            end
            ST_BI1: begin
                op         = OP_B_INIT1;
                state_next = ST_BLOOP;
            end
            ST_BLOOP: state_next = status.i_ge_p ? ST_CI0 : ST_BDIVG;
            ST_BDIVG: begin
                op         = OP_B_DIV_GO;
                state_next = ST_BDIVW;
            end
            ST_BDIVW: begin
                op = OP_B_DIV_END;
                if (status.div_done) begin
                    state_next = ST_BRDM;
                end
            end
            ST_BRDM: begin
                op         = OP_B_RDM;
                state_next = ST_BMULG;
            end
            ST_BMULG: begin
                op         = OP_B_MUL_GO;
                state_next = ST_BMULW;
            end
            ST_BMULW: begin
                op = OP_B_MUL_END;
                if (status.div_done) begin
                    state_next = ST_BLOOP;
                end
            end
            // factorial and inverse factorial prefix products
            ST_CI0: begin
                op         = OP_C_INIT0;
                state_next = ST_CI1;
            end
            ST_CI1: begin
                op         = OP_C_INIT1;
                state_next = ST_CLOOP;
            end
            ST_CLOOP: begin
                if (status.i_ge_p) begin
                    op         = OP_SET_READY;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_CFG;
                end
            end
            ST_CFG: begin
                op         = OP_C_FGO;
                state_next = ST_CFW;
            end
            ST_CFW: begin
                op = OP_C_FEND;
                if (status.div_done) begin
                    state_next = ST_CIG;
                end
            end
            ST_CIG: begin
                op         = OP_C_IGO;
                state_next = ST_CIW;
            end
            ST_CIW: begin
                op = OP_C_IEND;
                if (status.div_done) begin
                    state_next = ST_CLOOP;
                end
            end
            // digit loop
            ST_CMP: begin
                if (status.r_gt_n) begin
                    op         = OP_ZERO;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LTEST;
                end
            end
            ST_LTEST: state_next = status.n_zero ? ST_OUT : ST_NDG;
            ST_NDG: begin
                op         = OP_NDIV_GO;
                state_next = ST_NDW;
            end
            ST_NDW: begin
                op = OP_NDIV_END;
                if (status.div_done) begin
                    state_next = ST_RDG;
                end
            end
            ST_RDG: begin
                op         = OP_RDIV_GO;
                state_next = ST_RDW;
            end
            ST_RDW: begin
                op = OP_RDIV_END;
                if (status.div_done) begin
                    state_next = ST_DTEST;
                end
            end
            ST_DTEST: begin
                if (status.dr_gt_dn) begin
                    op         = OP_ZERO;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                op         = OP_RD_A;
                state_next = ST_M1G;
            end
            ST_M1G: begin
                op         = OP_M1_GO;
                state_next = ST_M1W;
            end
            ST_M1W: begin
                op = OP_M1_END;
                if (status.div_done) begin
                    state_next = ST_M2G;
                end
            end
            ST_M2G: begin
                op         = OP_M2_GO;
                state_next = ST_M2W;
            end
            ST_M2W: begin
                op = OP_M2_END;
                if (status.div_done) begin
                    state_next = ST_M3G;
                end
            end
            ST_M3G: begin
                op         = OP_M3_GO;
                state_next = ST_M3W;
            end
            ST_M3W: begin
                op = OP_M3_END;
                if (status.div_done) begin
                    state_next = ST_LTEST;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/binomial_mod_prime_lucas.sv @@
// Binomial coefficient C(n, r) mod p by Lucas' theorem, p a prime written on the
// config port (reset 2). One query word in, one residue word out; r > n gives 0,
// and a modulus below 2 or above MAX_PRIME gives 0. The first query after reset or
// after a modulus change first builds the factorial and inverse-factorial tables.
// A query then works through each base-p digit of n (up to 63 digits) on the
// bit-serial divider that every digit split and every modular product goes through.
// One query is in work at a time; a finished result waits in the output register
// while the next word is taken.
module binomial_mod_prime_lucas #(
    parameter int MAX_PRIME = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // top_value [62:0], choose_count [125:63], zero pad [127:126]
    input  logic [bml_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // binom_residue [11:0], zero pad [15:12]
    output logic [bml_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bml_pkg::VAL_W-1:0]       cfg_wr_data
);
    import bml_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    bml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    bml_datapath #(.MAX_PRIME(MAX_PRIME)) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .status      (status),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

@@ src/bml_checker.sv @@
`include "binomial_mod_prime_lucas_macros.svh"

module bml_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result word stays offered and unchanged
    `BML_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word dropped")
    `BML_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed")
    // one query in work: no new word right after an accept
    `BML_ASSERT(a_one_query, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second word taken")
    // residue fits twelve bits
    `BML_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[15:12] == 4'b0, "pad bits set")
    // reset empties the output register
    `BML_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

bind binomial_mod_prime_lucas bml_checker u_bml_checker (.*);

@@ tb/tb_binomial_mod_prime_lucas.sv @@
module tb_binomial_mod_prime_lucas;
    import bml_pkg::*;

    localparam int unsigned TBL_DEPTH = 4096;
    localparam int unsigned STALL_LIMIT = 2000000;

    // tracks the modulus, the tables and the residues still owed by the block
    class residue_tracker;
        int unsigned modulus;
        bit          tables_built;
        int unsigned fact_tbl[TBL_DEPTH];
        int unsigned inv_fact_tbl[TBL_DEPTH];
        logic [VAL_W-1:0] expected_residues[$];
        int unsigned mismatches;

        function new();
            modulus = 2;
            tables_built = 0;
            mismatches = 0;
        endfunction

        function void set_modulus(int unsigned p);
            if (p != modulus) begin
                modulus = p;
                tables_built = 0;
            end
        endfunction

        // linear inverse recurrence, then running products
        function void build_tables();
            int unsigned p;
            int unsigned i;
            int unsigned t;
            p = modulus;
            inv_fact_tbl[0] = 0;
            inv_fact_tbl[1] = 1 % p;
            for (i = 2; i < p; i++) begin
                t = ((p / i) * inv_fact_tbl[p % i]) % p;
                inv_fact_tbl[i] = (p - t) % p;
            end
            fact_tbl[0] = 1 % p;
            fact_tbl[1] = 1 % p;
            inv_fact_tbl[0] = 1 % p;
            for (i = 2; i < p; i++) begin
                fact_tbl[i] = (fact_tbl[i-1] * i) % p;
                inv_fact_tbl[i] = (inv_fact_tbl[i] * inv_fact_tbl[i-1]) % p;
            end
            tables_built = 1;
        endfunction

        function int unsigned lucas_residue(logic [NUM_W-1:0] n_in, logic [NUM_W-1:0] r_in);
            longint unsigned n;
            longint unsigned r;
            int unsigned p;
            int unsigned ans;
            int unsigned dn;
            int unsigned dr;
            int unsigned v;
            n = n_in;
            r = r_in;
            p = modulus;
            if (p < 2 || p > TBL_DEPTH) return 0;
            if (!tables_built) build_tables();
            if (r > n) return 0;
            ans = 1 % p;
            while (n != 0) begin
                dn = n % p;
                dr = r % p;
                if (dr > dn) begin
                    v = 0;
                end else begin
                    v = (fact_tbl[dn] * inv_fact_tbl[dn-dr]) % p;
                    v = (v * inv_fact_tbl[dr]) % p;
                end
                ans = (ans * v) % p;
                n = n / p;
                r = r / p;
            end
            return ans;
        endfunction

        function void note_query(logic [NUM_W-1:0] n, logic [NUM_W-1:0] r);
            int unsigned res;
            res = lucas_residue(n, r);
            expected_residues = {expected_residues, res[VAL_W-1:0]};
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            logic [OUT_TDATA_W-1:0] want;
            if (expected_residues.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            want = {{(OUT_TDATA_W-VAL_W){1'b0}}, expected_residues.pop_front()};
            if (word !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("residue mismatch: expected %h got %h (p=%0d)",
                             want, word, modulus);
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [VAL_W-1:0]       cfg_wr_data;

    residue_tracker tracker;
    int unsigned    s_idle_pct;
    int unsigned    m_stall_pct;
    int unsigned    quiet_cycles;

    binomial_mod_prime_lucas i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check each accepted word, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // one query word, with random sender gaps in front
    task automatic send_query(logic [NUM_W-1:0] n, logic [NUM_W-1:0] r);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r, n};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_query(n, r);
    endtask

    // modulus writes only once every residue is back
    task automatic write_modulus(int unsigned p);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_residues.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p[VAL_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_modulus(p);
    endtask

    function automatic logic [NUM_W-1:0] rand_bits(int unsigned width);
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if (width == 0) return '0;
        return NUM_W'(raw & ((64'd1 << width) - 64'd1));
    endfunction

    // random query: operand width mostly kept low for moduli below 64
    task automatic send_random(int unsigned p);
        int unsigned width;
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] r;
        if (p >= 64 || $urandom_range(0, 9) == 0) width = NUM_W;
        else width = $urandom_range(0, 16);
        n = rand_bits(width);
        case ($urandom_range(0, 3))
            0: r = n & rand_bits(width);
            1: r = rand_bits(width);
            2: r = n;
            default: r = rand_bits(width < NUM_W ? width + 1 : width);
        endcase
        send_query(n, r);
    endtask

    // stimulus
    initial begin
        int unsigned phase_mod[10] = '{3, 4093, 7, 0, 1, 6, 2, 13, 4, 4093};
        int unsigned phase_cnt[10] = '{35, 50, 35, 10, 10, 30, 35, 35, 20, 20};
        int unsigned stall_modes[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{9, 9}};
        logic [NUM_W-1:0] all_ones;
        tracker = new();
        all_ones = '1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_idle_pct = 0;
        m_stall_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed set at the reset modulus of two
        send_query(0, 0);
        send_query(0, all_ones);
        send_query(all_ones, 0);
        send_query(all_ones, all_ones);
        send_query(all_ones, 1);
        send_query(1, 0);
        send_query(1, 1);
        send_query(5, 7);
        send_query(6, 2);
        send_query(63'h5555_5555_5555_5555, 63'h1555_5555_5555_5555);
        // large prime: extremes and digit overflow
        write_modulus(4093);
        send_query(all_ones, all_ones);
        send_query(all_ones, 63'h2AAA_AAAA_AAAA_AAAA);
        send_query(4092, 4091);
        send_query(4093, 1);
        send_query(0, 0);
        send_query(10, 11);
        // modulus below two and a non-prime
        write_modulus(0);
        send_query(all_ones, 3);
        write_modulus(1);
        send_query(9, 4);
        write_modulus(9);
        send_query(8, 3);
        send_query(all_ones, 12345);

        // random phases, rotating the idle pattern
        for (int ph = 0; ph < 10; ph++) begin
            write_modulus(phase_mod[ph]);
            s_idle_pct  = stall_modes[ph % 4][0];
            m_stall_pct = stall_modes[ph % 4][1];
            for (int k = 0; k < phase_cnt[ph]; k++) send_random(phase_mod[ph]);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_residues.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
